/* rtl/mkbt_pkg.sv */
// ----------------------------------------------------------------------------
// mkbt_pkg
// shared types, codes and constants of the masked key binding match table
// ----------------------------------------------------------------------------
package mkbt_pkg;

  localparam int ENTRIES     = 64;
  localparam int SHIFT_BIT   = 0;
  localparam int CONTROL_BIT = 1;
  localparam int ALT_BIT     = 2;
  localparam int ANYMOD_BIT  = 8;
  localparam int SEND_CODE   = 0;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [15:0] SHIFT_M  = 16'(1) << SHIFT_BIT;
  localparam logic [15:0] CONTROL_M = 16'(1) << CONTROL_BIT;
  localparam logic [15:0] ALT_M    = 16'(1) << ALT_BIT;
  localparam logic [15:0] ANYMOD_M = 16'(1) << ANYMOD_BIT;
  localparam logic [15:0] ALL_CARE = 16'hffff;

  localparam logic [4:0] SEND_CMD  = 5'(SEND_CODE);
  localparam logic [7:0] LEN_LIMIT = 8'd16;
  localparam logic [5:0] CHAR_ONE  = 6'h31;

  // item operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef logic [IDX_W-1:0] idx_t;

  // query broadcast to every cell while an item is in flight
  typedef struct packed {
    logic        ins;
    logic [15:0] key;
    logic [15:0] mbits;
    logic [15:0] mask;
    logic [4:0]  cmd;
    logic [7:0]  len;
    logic [15:0] lref;
  } query_t;

  // token handed from cell to cell, carrying the answer so far
  typedef struct packed {
    logic        act;
    logic        hit;
    logic        placed;
    idx_t        idx;
    logic [4:0]  cmd;
    logic [7:0]  len;
    logic [15:0] lref;
    logic        meta;
    logic        subst;
  } tok_t;

endpackage

/* rtl/mkbt_cell.sv */
// ----------------------------------------------------------------------------
// mkbt_cell
// one table entry: ternary compare against the query, first-hit capture,
// and fill of the first free slot on insert
// ----------------------------------------------------------------------------
module mkbt_cell
  import mkbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  idx_t   cell_idx,
  input  query_t query,
  input  tok_t   tok_in,
  output tok_t   tok_out
);

  logic        valid_r;
  logic [15:0] key_r;
  logic [15:0] mbits_r;
  logic [15:0] mask_r;
  logic [4:0]  cmd_r;
  logic [7:0]  len_r;
  logic [15:0] lref_r;
  logic        act_r;
  tok_t        tok_r;
  tok_t        tok_nxt;

  logic        match;
  logic        take;
  logic        wr;
  logic [15:0] req_set;

  assign match = valid_r && (key_r == query.key) &&
                 (((mbits_r ^ query.mbits) & mask_r & query.mask) == 16'h0000);
  assign take  = tok_in.act && !tok_in.hit && match;
  // entries fill in order, so the first invalid cell reached is the free slot
  assign wr    = tok_in.act && (query.ins == OP_INSERT) && !tok_in.hit &&
                 !tok_in.placed && !valid_r;
  assign req_set = mask_r & mbits_r;

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.hit  = 1'b1;
      tok_nxt.idx  = cell_idx;
      tok_nxt.lref = lref_r;
      if (query.ins == OP_LOOKUP) begin
        tok_nxt.cmd   = cmd_r;
        tok_nxt.len   = len_r;
        tok_nxt.meta  = ((req_set & (ALT_M | ANYMOD_M)) != 16'h0000);
        tok_nxt.subst = (cmd_r == SEND_CMD) && ((req_set & ANYMOD_M) != 16'h0000) &&
                        (len_r < LEN_LIMIT);
      end
    end else if (wr) begin
      tok_nxt.placed = 1'b1;
      tok_nxt.idx    = cell_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      if (wr) begin
        valid_r <= 1'b1;
      end
      act_r <= tok_nxt.act;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      key_r   <= query.key;
      mbits_r <= query.mbits;
      mask_r  <= query.mask;
      cmd_r   <= query.cmd;
      len_r   <= query.len;
      lref_r  <= query.lref;
    end
    tok_r <= tok_nxt;
  end

  // active flag comes from the reset flop, the answer from the plain ones
  always_comb begin
    tok_out     = tok_r;
    tok_out.act = act_r;
  end

endmodule

/* rtl/masked_key_binding_match_table.sv */
// ----------------------------------------------------------------------------
// masked_key_binding_match_table
// ternary key binding table with first match in insertion order; inserts are
// checked for conflicts, lookups return the bound command and star handling
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, in_cmd .. in_line_ref | into block
//  out     | out_valid, out_stall, out_status ..     | out of block
//
//  an accepted item is registered as the query and a token enters cell 0 the
//  next cycle; the token walks one cell per cycle down the row of ENTRIES
//  cells, and the result is registered in the output register as the token
//  leaves the last cell
//  one item is in the row at a time; the next item is taken once the result
//  has been captured in the output register and that register is free or
//  being emptied in the same cycle
//  reset empties the table at once (valid flags in flops) and drops any item
//  out_stall holds the result in the output register; nothing else waits
//
module masked_key_binding_match_table
  import mkbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [15:0] in_key_code,
  input  logic [15:0] in_mode_bits,
  input  logic [15:0] in_entry_mask,
  input  logic [4:0]  in_entry_command,
  input  logic [7:0]  in_text_length,
  input  logic [15:0] in_line_ref,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [5:0]  out_entry_index,
  output logic [4:0]  out_command_out,
  output logic [7:0]  out_length_out,
  output logic [15:0] out_ref_out,
  output logic        out_meta_specified,
  output logic        out_substitute,
  output logic [5:0]  out_substitute_char
);

  // control
  logic busy_r;
  logic busy_nxt;
  logic start_r;
  logic out_valid_r;
  logic out_valid_nxt;
  logic in_acc;
  logic out_acc;
  logic done;

  // query held for the whole walk down the row
  query_t      q_r;
  query_t      q_nxt;
  logic [5:0]  sch_r;
  logic [5:0]  sch_nxt;
  logic [15:0] look_bits;

  // result register
  logic [1:0]  status_r;
  logic [1:0]  status_nxt;
  logic [5:0]  idx_out_r;
  logic [4:0]  cmd_out_r;
  logic [7:0]  len_out_r;
  logic [15:0] ref_out_r;
  logic        meta_r;
  logic        subst_r;
  logic [5:0]  sch_out_r;

  // the cell row
  tok_t             tok [ENTRIES+1];
  logic [ENTRIES-1:0] act_vec;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = busy_r || (out_valid_r && out_stall);
  assign done    = tok[ENTRIES].act;

  // lookup: any of shift, alt, control implies the any-modifier bit
  always_comb begin
    look_bits = in_mode_bits;
    if ((in_mode_bits & (SHIFT_M | ALT_M | CONTROL_M)) != 16'h0000) begin
      look_bits = in_mode_bits | ANYMOD_M;
    end
  end

  always_comb begin
    q_nxt       = q_r;
    sch_nxt     = sch_r;
    if (in_acc) begin
      q_nxt.ins  = in_cmd;
      q_nxt.key  = in_key_code;
      q_nxt.cmd  = in_entry_command;
      q_nxt.len  = in_text_length;
      q_nxt.lref = in_line_ref;
      if (in_cmd == OP_LOOKUP) begin
        q_nxt.mbits = look_bits;
        q_nxt.mask  = ALL_CARE;
        // replacement digit from shift, alt and control of the keystroke
        sch_nxt = CHAR_ONE + 6'({5'b0, (look_bits & SHIFT_M) != 16'h0000}) +
                  6'({4'b0, (look_bits & ALT_M) != 16'h0000, 1'b0}) +
                  6'({3'b0, (look_bits & CONTROL_M) != 16'h0000, 2'b0});
      end else begin
        q_nxt.mbits = in_mode_bits;
        q_nxt.mask  = in_entry_mask;
        sch_nxt     = CHAR_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    sch_r <= sch_nxt;
  end

  // token entering the first cell: blank answer, active for one cycle
  always_comb begin
    tok[0]     = '0;
    tok[0].act = start_r;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    mkbt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (idx_t'(g)),
      .query    (q_r),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1])
    );
    assign act_vec[g] = tok[g+1].act;
  end

  // busy from accept until the token leaves the last cell
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_acc) begin
      out_valid_nxt = 1'b0;
    end
  end

  // final status from what the token gathered
  always_comb begin
    if (q_r.ins == OP_LOOKUP) begin
      status_nxt = tok[ENTRIES].hit ? ST_OK : ST_NOTFOUND;
    end else if (tok[ENTRIES].hit) begin
      status_nxt = ST_CONFLICT;
    end else if (tok[ENTRIES].placed) begin
      status_nxt = ST_OK;
    end else begin
      status_nxt = ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      start_r     <= in_acc;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status_r  <= status_nxt;
      idx_out_r <= 6'(tok[ENTRIES].idx);
      cmd_out_r <= tok[ENTRIES].cmd;
      len_out_r <= tok[ENTRIES].len;
      ref_out_r <= tok[ENTRIES].lref;
      meta_r    <= tok[ENTRIES].meta;
      subst_r   <= tok[ENTRIES].subst;
      sch_out_r <= sch_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_entry_index    = idx_out_r;
  assign out_command_out    = cmd_out_r;
  assign out_length_out     = len_out_r;
  assign out_ref_out        = ref_out_r;
  assign out_meta_specified = meta_r;
  assign out_substitute     = subst_r;
  assign out_substitute_char = sch_out_r;

`ifndef SYNTHESIS
  // only one item walks the row at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(act_vec) <= 1)
    else $error("more than one token in the cell row");

  // a result only appears after the token left the last cell
  a_out_from_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(done))
    else $error("result without a finished walk");

  // a full table reports no slot
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == ST_FULL)) |-> (idx_out_r == 6'd0))
    else $error("full status with nonzero index");

  // the token enters the row right after accept
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (start_r && busy_r))
    else $error("accepted item did not enter the row");
`endif

endmodule
